/* rtl/core/apsd_pkg.sv */
package apsd_pkg;

    // Field widths
    localparam int DIST_W   = 24;
    localparam int WEIGHT_W = 16;
    localparam int NODE_W   = 4;
    localparam int NCOUNT_W = 5;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // No-path code
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    // Node count after reset
    localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 5'd16;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;

    // Request from the front end to the relaxation engine
    typedef struct packed {
        logic start;
        logic recompute;
    } t_relax_cmd;

    // Answer from the relaxation engine
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] path_len;
    } t_relax_stat;

endpackage

/* rtl/core/apsd_edge_store.sv */
module apsd_edge_store #(
    parameter int MAX_NODES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_wen,
    input  logic [2*$clog2(MAX_NODES)-1:0]      i_waddr,
    input  logic [apsd_pkg::WEIGHT_W-1:0]       i_wdata,
    input  logic [2*$clog2(MAX_NODES)-1:0]      i_raddr,
    output logic [apsd_pkg::WEIGHT_W-1:0]       o_rdata
);
    import apsd_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;

    logic [WEIGHT_W-1:0] r_mem [DEPTH];
    logic [WEIGHT_W-1:0] r_rdata;

    // Write one weight, read one weight with a registered output
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/apsd_relax.sv */
module apsd_relax #(
    parameter int MAX_NODES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  apsd_pkg::t_relax_cmd                i_cmd,
    input  logic [$clog2(MAX_NODES)-1:0]        i_last,
    input  logic [2*$clog2(MAX_NODES)-1:0]      i_qaddr,
    output logic [2*$clog2(MAX_NODES)-1:0]      o_edge_raddr,
    input  logic [apsd_pkg::WEIGHT_W-1:0]       i_edge_rdata,
    output apsd_pkg::t_relax_stat               o_stat
);
    import apsd_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [8:0] {
        R_IDLE  = 9'b000000001,
        R_INIT  = 9'b000000010,
        R_GAP   = 9'b000000100,
        R_HEAD  = 9'b000001000,
        R_HEADW = 9'b000010000,
        R_SWEEP = 9'b000100000,
        R_DRAIN = 9'b001000000,
        R_LOOK  = 9'b010000000,
        R_LOOKW = 9'b100000000
    } t_relax_state;

    t_relax_state r_state, n_state;
    logic [NW-1:0] r_k, n_k;
    logic [NW-1:0] r_i, n_i;
    logic [NW-1:0] r_j, n_j;
    logic [NW-1:0] r_last, n_last;
    logic [AW-1:0] r_qaddr, n_qaddr;
    logic [DIST_W-1:0] r_dik, n_dik;

    // Write-back pipeline: init copy and relax update
    logic          r_iv;
    logic [AW-1:0] r_iaddr;
    logic          r_sv;
    logic [AW-1:0] r_saddr;

    // Distance memory, one write and two registered reads
    logic [DIST_W-1:0] r_mem [DEPTH];
    logic [DIST_W-1:0] r_rd_a;
    logic [DIST_W-1:0] r_rd_b;

    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [DIST_W:0]   sum;
    logic              take;
    logic [DIST_W-1:0] init_val;
    logic              wen;
    logic [AW-1:0]     waddr;
    logic [DIST_W-1:0] wdata;

    // Read ports: A walks row k, B serves row head, sweep target and lookup
    always_comb begin
        raddr_a = {r_k, r_j};
        if (r_state == R_HEAD) begin
            raddr_b = {r_i, r_k};
        end else if (r_state == R_LOOK) begin
            raddr_b = r_qaddr;
        end else begin
            raddr_b = {r_i, r_j};
        end
    end

    assign o_edge_raddr = {r_i, r_j};

    // Copy an edge, or relax one entry: take the path through k only when it is shorter and finite
    always_comb begin
        sum  = {1'b0, r_dik} + {1'b0, r_rd_a};
        take = r_sv && (r_dik != DIST_INF) && (r_rd_a != DIST_INF)
               && (sum < {1'b0, DIST_INF}) && (sum < {1'b0, r_rd_b});
        init_val = (i_edge_rdata != '0) ?
                   {{(DIST_W-WEIGHT_W){1'b0}}, i_edge_rdata} : DIST_INF;
        wen   = r_iv || take;
        waddr = r_iv ? r_iaddr : r_saddr;
        wdata = r_iv ? init_val : sum[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[raddr_b];
    end

    // Sequencer: on recompute copy edges and run the k / i / j sweeps, then look up the query
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_last  = r_last;
        n_qaddr = r_qaddr;
        n_dik   = r_dik;
        case (r_state)
            R_IDLE: begin
                if (i_cmd.start) begin
                    n_last  = i_last;
                    n_qaddr = i_qaddr;
                    n_k     = '0;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = i_cmd.recompute ? R_INIT : R_LOOK;
                end
            end
            R_INIT: begin
                if (r_j == r_last) begin
                    n_j = '0;
                    if (r_i == r_last) begin
                        n_i     = '0;
                        n_state = R_GAP;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            R_GAP: begin
                n_state = R_HEAD;
            end
            R_HEAD: begin
                n_state = R_HEADW;
            end
            R_HEADW: begin
                n_dik   = r_rd_b;
                n_j     = '0;
                n_state = R_SWEEP;
            end
            R_SWEEP: begin
                if (r_j == r_last) begin
                    n_state = R_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            R_DRAIN: begin
                if (r_i == r_last) begin
                    n_i = '0;
                    if (r_k == r_last) begin
                        n_state = R_LOOK;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = R_HEAD;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = R_HEAD;
                end
            end
            R_LOOK: begin
                n_state = R_LOOKW;
            end
            R_LOOKW: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_iv    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iv    <= (r_state == R_INIT);
            r_sv    <= (r_state == R_SWEEP);
        end
        r_k     <= n_k;
        r_i     <= n_i;
        r_j     <= n_j;
        r_last  <= n_last;
        r_qaddr <= n_qaddr;
        r_dik   <= n_dik;
        r_iaddr <= {r_i, r_j};
        r_saddr <= {r_i, r_j};
    end

    assign o_stat.done     = (r_state == R_LOOKW);
    assign o_stat.path_len = r_rd_b;

endmodule

/* rtl/core/all_pairs_shortest_distance.sv */
// All-pairs shortest distance over a stored edge-weight matrix.
// Input channel (i_in_valid / o_in_stall): a write item stores one edge weight
// (zero means no edge); a query item returns one result on the output channel
// (o_out_valid / i_out_stall) with the distance and a reachable flag. No path
// is reported as all ones with reachable low, as is a node against itself.
// Node count is set over the APB port at address 0; the user writes it only while
// the block is idle, and the block itself does not enforce it. Per item:
//   write item: stored on its transfer, no result.
//   query with current distances: lookup in R_LOOK and R_LOOKW, then the result.
//   query after an edit or a node count write: the edges are copied into the
//   distance memory, rows are relaxed for every k, then the lookup. The single
//   write port of the distance memory takes one entry a cycle in the sweep,
//   with head reads (R_HEAD, R_HEADW) before and a drain state after each row.
// One item is worked at a time; the input is stalled while a query runs.
// Reset: the edge memory is cleared in a pass over all 4^ceil(log2 MAX_NODES)
// entries (256 at default); the input stalls meanwhile, APB writes still land.
// A finished result waits in the output register while the receiver stalls;
// write items keep flowing, and the next query waits only for that slot.
module all_pairs_shortest_distance #(
    parameter int MAX_NODES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [apsd_pkg::NODE_W-1:0]       i_row,
    input  logic [apsd_pkg::NODE_W-1:0]       i_col,
    input  logic [apsd_pkg::WEIGHT_W-1:0]     i_weight,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [apsd_pkg::DIST_W-1:0]       o_distance,
    output logic                              o_reachable,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [apsd_pkg::ADDR_W-1:0]       paddr,
    input  logic [apsd_pkg::DATA_W-1:0]       pwdata,
    output logic [apsd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import apsd_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = 2 * NW;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = (CW > NCOUNT_W) ? CW : NCOUNT_W;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_NODES);

    typedef enum logic [3:0] {
        T_CLEAR  = 4'b0001,
        T_IDLE   = 4'b0010,
        T_BUSY   = 4'b0100,
        T_ANSWER = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_stale, n_stale;
    logic [NCOUNT_W-1:0] r_node_count, n_node_count;
    logic                r_hit, n_hit;
    logic [DIST_W-1:0]   r_res_dist, n_res_dist;
    logic                r_res_reach, n_res_reach;
    logic                r_out_valid, n_out_valid;
    logic [DIST_W-1:0]   r_out_dist, n_out_dist;
    logic                r_out_reach, n_out_reach;

    logic [XW-1:0]       nc_x;
    logic [XW-1:0]       n_eff_x;
    logic [XW-1:0]       last_x;
    logic [XW-1:0]       row_x;
    logic [XW-1:0]       col_x;
    logic                in_range;
    logic [AW-1:0]       node_addr;
    logic                cfg_hit;
    logic                out_free;
    logic                found;

    logic                edge_wen;
    logic [AW-1:0]       edge_waddr;
    logic [WEIGHT_W-1:0] edge_wdata;
    logic [AW-1:0]       edge_raddr;
    logic [WEIGHT_W-1:0] edge_rdata;
    t_relax_cmd          cmd;
    t_relax_stat         stat;

    // Clamp the node count into 1..MAX_NODES
    always_comb begin
        nc_x = XW'(r_node_count);
        if (r_node_count == '0) begin
            n_eff_x = XW'(1);
        end else if (nc_x > MAX_X) begin
            n_eff_x = MAX_X;
        end else begin
            n_eff_x = nc_x;
        end
        last_x    = n_eff_x - XW'(1);
        row_x     = XW'(i_row);
        col_x     = XW'(i_col);
        in_range  = (row_x < n_eff_x) && (col_x < n_eff_x);
        node_addr = {row_x[NW-1:0], col_x[NW-1:0]};
    end

    assign cfg_hit    = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_NODE_COUNT) ?
                        {{(DATA_W-NCOUNT_W){1'b0}}, r_node_count} : '0;
    assign o_in_stall = (r_state != T_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign found      = r_hit && (stat.path_len != DIST_INF);

    // Front-end control: clear pass, item intake, result hand-off
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_stale      = r_stale;
        n_node_count = r_node_count;
        n_hit        = r_hit;
        n_res_dist   = r_res_dist;
        n_res_reach  = r_res_reach;
        n_out_valid  = r_out_valid;
        n_out_dist   = r_out_dist;
        n_out_reach  = r_out_reach;
        edge_wen     = 1'b0;
        edge_waddr   = node_addr;
        edge_wdata   = i_weight;
        cmd          = '0;

        // Drop the result once its transfer completes
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            T_CLEAR: begin
                edge_wen   = 1'b1;
                edge_waddr = r_clr_addr;
                edge_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = T_IDLE;
                end
            end
            T_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_WRITE) begin
                        if (in_range) begin
                            edge_wen = 1'b1;
                            n_stale  = 1'b1;
                        end
                    end else begin
                        cmd.start     = 1'b1;
                        cmd.recompute = r_stale;
                        n_stale       = 1'b0;
                        n_hit         = in_range && (i_row != i_col);
                        n_state       = T_BUSY;
                    end
                end
            end
            T_BUSY: begin
                if (stat.done) begin
                    n_res_dist  = found ? stat.path_len : DIST_INF;
                    n_res_reach = found;
                    n_state     = T_ANSWER;
                end
            end
            T_ANSWER: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_res_dist;
                    n_out_reach = r_res_reach;
                    n_state     = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase

        // Register write: new node count, distances go stale
        if (cfg_hit) begin
            n_node_count = pwdata[NCOUNT_W-1:0];
            n_stale      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_CLEAR;
            r_clr_addr   <= '0;
            r_stale      <= 1'b1;
            r_node_count <= NCOUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_stale      <= n_stale;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
        r_hit       <= n_hit;
        r_res_dist  <= n_res_dist;
        r_res_reach <= n_res_reach;
        r_out_dist  <= n_out_dist;
        r_out_reach <= n_out_reach;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_reachable = r_out_reach;

    apsd_edge_store #(
        .MAX_NODES (MAX_NODES)
    ) u_edge_store (
        .i_clk   (i_clk),
        .i_wen   (edge_wen),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    apsd_relax #(
        .MAX_NODES (MAX_NODES)
    ) u_relax (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_last       (last_x[NW-1:0]),
        .i_qaddr      (node_addr),
        .o_edge_raddr (edge_raddr),
        .i_edge_rdata (edge_rdata),
        .o_stat       (stat)
    );

endmodule

/* rtl/core/apsd_checker.sv */
module apsd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_action,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [apsd_pkg::DIST_W-1:0]    o_distance,
    input logic                           o_reachable
);
    import apsd_pkg::*;

    // The clear pass holds off input right after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // A query transfer occupies the block on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_QUERY)) |=> o_in_stall)
        else $error("input accepted while a query runs");

    // A write transfer never makes a result appear
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_WRITE) && !o_out_valid)
        |=> !o_out_valid)
        else $error("result after a write item");

    // Reachable flag and no-path code agree
    a_reach_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reachable == (o_distance != DIST_INF)))
        else $error("reachable flag disagrees with distance");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_distance) && $stable(o_reachable)))
        else $error("stalled result changed");

endmodule

bind all_pairs_shortest_distance apsd_checker u_apsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_distance  (o_distance),
    .o_reachable (o_reachable)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import apsd_pkg::*;

    localparam int NODES_MAX    = 16;
    localparam int QUIET_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PLAN_LEN     = 25;
    localparam logic [ADDR_W-1:0] NODE_COUNT_ADDR = ADDR_W'({REG_NODE_COUNT, 2'b00});

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

    // One directed step: an item, or a node count write carried in wt
    typedef struct packed {
        step_kind_e          kind;
        logic                act;
        logic [NODE_W-1:0]   row;
        logic [NODE_W-1:0]   col;
        logic [WEIGHT_W-1:0] wt;
        logic                typed;
        logic [DIST_W-1:0]   exp_len;
        logic                reach;
    } step_t;

    typedef struct packed {
        logic [DIST_W-1:0] len;
        logic              reach;
    } answer_t;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_action   = ACT_WRITE;
    logic [NODE_W-1:0]   i_row      = '0;
    logic [NODE_W-1:0]   i_col      = '0;
    logic [WEIGHT_W-1:0] i_weight   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DIST_W-1:0]   o_distance;
    logic                o_reachable;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Hand-typed answer that travels with the current item
    logic                typed_on    = 1'b0;
    logic [DIST_W-1:0]   typed_dist  = '0;
    logic                typed_reach = 1'b0;

    int send_gap_pct  = 0;
    int out_stall_pct = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    // Predicted graph state
    logic [WEIGHT_W-1:0] edge_len [NODES_MAX][NODES_MAX];
    logic [DIST_W-1:0]   dist_tab [NODES_MAX][NODES_MAX];
    logic                dist_stale;
    logic [NCOUNT_W-1:0] node_cfg;

    answer_t dist_answers[$];

    step_t plan [PLAN_LEN] = '{
        // no edges after reset
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd1,  16'h0000, 1'b1, DIST_INF, 1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd0,  4'd1,  16'h0001, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd1,  4'd2,  16'hFFFF, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd2,  4'd15, 16'h8000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd15, 4'd15, 16'hFFFF, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd15, 4'd0,  16'h0001, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd15, 16'hFFFF, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd15, 4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd3,  4'd0,  16'h0000, 1'b0, 24'd0,    1'b0},
        // node against itself, even with a self loop stored
        '{STEP_ITEM, ACT_QUERY, 4'd15, 4'd15, 16'h0000, 1'b1, DIST_INF, 1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd0,  4'd1,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd15, 4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_CFG,  ACT_WRITE, 4'd0,  4'd0,  16'd3,    1'b0, 24'd0,    1'b0},
        // write outside the node count is dropped
        '{STEP_ITEM, ACT_WRITE, 4'd5,  4'd1,  16'h0007, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_WRITE, 4'd0,  4'd2,  16'h0005, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd5,  16'h0000, 1'b1, DIST_INF, 1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd1,  4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        // zero node count acts as one node
        '{STEP_CFG,  ACT_WRITE, 4'd0,  4'd0,  16'd0,    1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd0,  16'h0000, 1'b1, DIST_INF, 1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd0,  4'd1,  16'h0000, 1'b1, DIST_INF, 1'b0},
        // oversized node count clamps; stored edges come back
        '{STEP_CFG,  ACT_WRITE, 4'd0,  4'd0,  16'd31,   1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd15, 4'd2,  16'h0000, 1'b0, 24'd0,    1'b0},
        '{STEP_ITEM, ACT_QUERY, 4'd5,  4'd1,  16'h0000, 1'b0, 24'd0,    1'b0}
    };

    all_pairs_shortest_distance #(
        .MAX_NODES(NODES_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_weight    (i_weight),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .o_reachable (o_reachable),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Rebuild all distances from the edge matrix
    function automatic void relax_paths(input int n);
        int unsigned dik;
        int unsigned dkj;
        int unsigned via;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                dist_tab[i][j] = (edge_len[i][j] != '0) ? DIST_W'(edge_len[i][j]) : DIST_INF;
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                dik = dist_tab[i][k];
                if (dik == DIST_INF) continue;
                for (int j = 0; j < n; j++) begin
                    dkj = dist_tab[k][j];
                    if (dkj == DIST_INF) continue;
                    via = dik + dkj;
                    if (via < DIST_INF && via < dist_tab[i][j]) dist_tab[i][j] = via[DIST_W-1:0];
                end
            end
        end
    endfunction

    // Apply one item to the predicted graph; answers is set for queries
    function automatic void predict_item(input logic act, input logic [NODE_W-1:0] r,
                                         input logic [NODE_W-1:0] c,
                                         input logic [WEIGHT_W-1:0] w,
                                         output logic [DIST_W-1:0] d, output logic rch,
                                         output bit answers);
        int n;
        n = (node_cfg == '0) ? 1 : ((node_cfg > NODES_MAX) ? NODES_MAX : int'(node_cfg));
        d = DIST_INF;
        rch = 1'b0;
        answers = 1'b0;
        if (act == ACT_WRITE) begin
            if (r < n && c < n) begin
                edge_len[r][c] = w;
                dist_stale = 1'b1;
            end
            return;
        end
        answers = 1'b1;
        if (dist_stale) begin
            relax_paths(n);
            dist_stale = 1'b0;
        end
        if (r < n && c < n && r != c && dist_tab[r][c] != DIST_INF) begin
            d = dist_tab[r][c];
            rch = 1'b1;
        end
    endfunction

    // Watch all three ports: check results, predict on input transfers, track config
    always @(posedge i_clk) begin : scoreboard
        answer_t want;
        logic [DIST_W-1:0] d;
        logic rch;
        bit answers;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            moved = 1'b1;
            if (dist_answers.size() == 0) begin
                flag_mismatch("result with no query outstanding");
            end else begin
                want = dist_answers.pop_front();
                if (o_distance !== want.len)
                    flag_mismatch($sformatf("distance %0d, predicted %0d",
                                            o_distance, want.len));
                if (o_reachable !== want.reach)
                    flag_mismatch($sformatf("reachable %b, predicted %b",
                                            o_reachable, want.reach));
            end
        end
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            moved = 1'b1;
            predict_item(i_action, i_row, i_col, i_weight, d, rch, answers);
            if (answers) begin
                if (typed_on) begin
                    want.len   = typed_dist;
                    want.reach = typed_reach;
                end else begin
                    want.len   = d;
                    want.reach = rch;
                end
                dist_answers = {dist_answers, want};
            end
        end
        if (psel && penable && pwrite && pready === 1'b1) begin
            moved = 1'b1;
            if (paddr == NODE_COUNT_ADDR) begin
                node_cfg   = pwdata[NCOUNT_W-1:0];
                dist_stale = 1'b1;
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // End the run when no transfer of any kind happens for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // Present one item, hold it until the transfer, leave valid high
    task automatic drive_item(input logic act, input logic [NODE_W-1:0] r,
                              input logic [NODE_W-1:0] c, input logic [WEIGHT_W-1:0] w,
                              input logic typed, input logic [DIST_W-1:0] d,
                              input logic rch);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_row       <= r;
        i_col       <= c;
        i_weight    <= w;
        typed_on    <= typed;
        typed_dist  <= d;
        typed_reach <= rch;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    // Drop valid and hold until every query has answered
    task automatic wait_answers(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (dist_answers.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [NCOUNT_W-1:0] v);
        wait_answers(DRAIN_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly in-range nodes, some anywhere in the field
    function automatic logic [NODE_W-1:0] pick_node(input int n);
        if ($urandom_range(0, 99) < 88) return NODE_W'($urandom_range(0, n - 1));
        return NODE_W'($urandom_range(0, 15));
    endfunction

    task automatic run_phase(input logic [NCOUNT_W-1:0] cfg, input int items,
                             input int gap_pct, input int hold_pct);
        int n;
        logic act;
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] c;
        logic [WEIGHT_W-1:0] w;
        write_node_count(cfg);
        send_gap_pct  = gap_pct;
        out_stall_pct = hold_pct;
        n = (cfg == '0) ? 1 : ((cfg > NODES_MAX) ? NODES_MAX : int'(cfg));
        for (int k = 0; k < items; k++) begin
            // pause halfway until every query is answered
            if (k == items / 2) wait_answers(0);
            act = ($urandom_range(0, 99) < 55) ? ACT_WRITE : ACT_QUERY;
            r = pick_node(n);
            c = pick_node(n);
            case ($urandom_range(0, 9))
                0, 1:          w = '0;
                2, 3, 4, 5, 6: w = WEIGHT_W'($urandom_range(1, 40));
                default:       w = WEIGHT_W'($urandom);
            endcase
            drive_item(act, r, c, w, 1'b0, DIST_INF, 1'b0);
        end
    endtask

    initial begin
        for (int i = 0; i < NODES_MAX; i++) begin
            for (int j = 0; j < NODES_MAX; j++) begin
                edge_len[i][j] = '0;
                dist_tab[i][j] = '0;
            end
        end
        dist_stale = 1'b1;
        node_cfg   = NCOUNT_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed steps, sender idling lightly and receiver heavily
        send_gap_pct  = 29;
        out_stall_pct = 74;
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (plan[k].kind == STEP_CFG)
                write_node_count(plan[k].wt[NCOUNT_W-1:0]);
            else
                drive_item(plan[k].act, plan[k].row, plan[k].col, plan[k].wt,
                           plan[k].typed, plan[k].exp_len, plan[k].reach);
        end

        // Random traffic: idling swapped between phases, large graph kept short
        run_phase(5'd6, 50, 29, 74);
        run_phase(5'd10, 50, 74, 29);
        run_phase(5'd16, 20, 0, 0);

        wait_answers(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/apsd_pkg.sv
rtl/core/apsd_edge_store.sv
rtl/core/apsd_relax.sv
rtl/core/all_pairs_shortest_distance.sv
rtl/core/apsd_checker.sv
dv/tb.sv
